@@ rtl/nnd_pkg.sv @@
`default_nettype none
package nnd_pkg;

   localparam int PACKET_BYTES = 1024;
   localparam int PKT_AW       = $clog2(PACKET_BYTES);
   localparam int OFF_W        = PKT_AW + 1;
   localparam int SCOPE_BYTES  = 64;
   localparam int SCOPE_AW     = $clog2(SCOPE_BYTES);
   localparam int SN_W         = SCOPE_AW + 1;
   localparam int MAX_HOPS     = 10;
   localparam int HOP_W        = $clog2(MAX_HOPS + 1);
   localparam int LABEL_LIMIT  = 10;
   localparam int LBL_W        = $clog2(LABEL_LIMIT + 1);
   localparam int NAME_BYTES   = 16;
   localparam int QDEPTH       = 2;
   localparam int QPTR_W       = $clog2(QDEPTH);
   localparam int REQ_W        = 32;
   localparam int RSP_W        = 168;

   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [1:0] PTR_MARK   = 2'b11;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [9:0]  position;
      logic [7:0]  byte_value;
      logic [10:0] packet_length;
   } nnd_req_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_F_HEAD,
      ST_F_CHK,
      ST_F_PTR,
      ST_N_LEN,
      ST_N_RD1,
      ST_N_RD2,
      ST_N_PAIR,
      ST_N_END,
      ST_STRIP,
      ST_S_HEAD,
      ST_S_CHK,
      ST_S_LEN,
      ST_S_RD,
      ST_S_CPY,
      ST_E_RD,
      ST_E_OUT,
      ST_SUM
   } nnd_state_type;

endpackage
`default_nettype wire

@@ rtl/netbios_name_decoder_top.sv @@
`default_nettype none
// NetBIOS name decoder. A load transfer (tuser 0) writes one packet byte; a
// decode transfer (tuser 1) walks the packet buffer through its single read
// port: it follows pointers, reads name character pairs, copies scope
// characters and then emits them. A decode produces its scope characters
// (tuser 0) and then one summary with tlast set. A two-entry queue sits in
// front, so up to two transfers are taken while a decode runs, and results
// leave through a registered output stage.
module netbios_name_decoder_top (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // position[9:0], byte_value[17:10], packet_length[28:18], zero pad
   input  wire logic [nnd_pkg::REQ_W-1:0] req_tdata,
   // cmd
   input  wire logic                 req_tuser,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // scope_char[7:0], ok[8], consumed[19:9], name_front[83:20],
   // name_back[147:84], name_length[152:148], type_byte[160:153],
   // scope_length[166:161], zero pad
   output logic [nnd_pkg::RSP_W-1:0] rsp_tdata,
   output logic                      rsp_tlast,
   // is_summary
   output logic                      rsp_tuser
);

   logic                 q_valid;
   logic                 q_pop;
   nnd_pkg::nnd_req_type q_item;

   nnd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   nnd_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

@@ rtl/nnd_front.sv @@
`default_nettype none
module nnd_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // fields from bit 0: position[9:0], byte_value[17:10], packet_length[28:18], zero pad
   input  wire logic [nnd_pkg::REQ_W-1:0] req_tdata,
   // fields: cmd
   input  wire logic                 req_tuser,
   output logic                      q_valid,
   output nnd_pkg::nnd_req_type      q_item,
   input  wire logic                 q_pop
);

   nnd_pkg::nnd_req_type                 entry_ff [nnd_pkg::QDEPTH];
   nnd_pkg::nnd_req_type                 item_in;
   logic [nnd_pkg::QPTR_W-1:0]           wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [nnd_pkg::QPTR_W:0]             count_ff, count_in;
   logic                                 push;
   logic [10:0]                          len_raw;

   assign req_tready = count_ff < (nnd_pkg::QPTR_W + 1)'(nnd_pkg::QDEPTH);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = count_ff != '0;
   assign q_item     = entry_ff[rd_ptr_ff];

   // The length is saturated here so that the engine only sees usable bounds.
   always_comb begin
      len_raw                = req_tdata[28:18];
      item_in.cmd            = req_tuser;
      item_in.position       = req_tdata[9:0];
      item_in.byte_value     = req_tdata[17:10];
      item_in.packet_length  = (len_raw > 11'(nnd_pkg::PACKET_BYTES)) ?
                               11'(nnd_pkg::PACKET_BYTES) : len_raw;
   end

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (nnd_pkg::QPTR_W + 1)'(push) - (nnd_pkg::QPTR_W + 1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/nnd_engine.sv @@
`default_nettype none
module nnd_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   input  wire nnd_pkg::nnd_req_type q_item,
   output logic                      q_pop,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic                      rsp_tlast,
   output logic                      rsp_tuser,
   output logic [nnd_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int OW = nnd_pkg::OFF_W;

   nnd_pkg::nnd_state_type state_ff, state_in;

   logic [7:0]                  pkt_mem [nnd_pkg::PACKET_BYTES];
   logic [7:0]                  scope_mem [nnd_pkg::SCOPE_BYTES];
   logic [7:0]                  pkt_rd_ff, scope_rd_ff;
   logic                        oob_ff;
   logic [OW-1:0]               raddr;
   logic [7:0]                  rd_byte;

   logic [OW-1:0]               off_ff, off_in, len_ff, len_in;
   logic [11:0]                 ret_ff, ret_in;
   logic                        gp_ff, gp_in, ok_ff, ok_in, scope_ff, scope_in;
   logic [7:0]                  m_ff, m_in, c1_ff, c1_in, ntype_ff, ntype_in;
   logic [5:0]                  hi_ff, hi_in;
   logic [nnd_pkg::HOP_W-1:0]   hops_ff, hops_in;
   logic [nnd_pkg::LBL_W-1:0]   labels_ff, labels_in;
   logic [4:0]                  nidx_ff, nidx_in;
   logic [3:0]                  k_ff, k_in;
   logic [nnd_pkg::SN_W-1:0]    sn_ff, sn_in, e_ff, e_in, sn_dot;
   logic [7:0]                  name_ff [nnd_pkg::NAME_BYTES];
   logic [7:0]                  name_in [nnd_pkg::NAME_BYTES];

   logic                        scope_we;
   logic [nnd_pkg::SCOPE_AW-1:0] scope_waddr;
   logic [7:0]                  scope_wdata;

   logic                        out_free, out_load, rsp_valid_ff, rsp_valid_in;
   logic                        rsp_last_ff, rsp_last_in, rsp_user_ff, rsp_user_in;
   logic [nnd_pkg::RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [13:0]                 target;
   logic [7:0]                  c2;
   logic                        start_bad, ptr_bad, nlen_bad, pair_bad, slen_bad;
   logic [63:0]                 front_w, back_w;

   assign rd_byte  = oob_ff ? 8'h00 : pkt_rd_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign q_pop    = (state_ff == nnd_pkg::ST_IDLE) && q_valid;
   assign target   = {hi_ff, rd_byte};
   assign c2       = rd_byte - nnd_pkg::CHAR_A;
   assign sn_dot   = sn_ff + nnd_pkg::SN_W'(sn_ff != '0);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The second byte of a pointer and of a character pair sits one above off.
   assign raddr = off_ff + OW'((state_ff == nnd_pkg::ST_F_CHK && rd_byte[7:6] ==
                               nnd_pkg::PTR_MARK) || state_ff == nnd_pkg::ST_N_RD2);

   always_comb begin
      start_bad = {1'b0, q_item.packet_length} < 12'(q_item.position) + 12'd2;
      ptr_bad   = (hops_ff == nnd_pkg::HOP_W'(nnd_pkg::MAX_HOPS)) ||
                  (15'(target) + 15'd2 > 15'(len_ff));
      nlen_bad  = (m_ff == 8'd0) || (m_ff[7:6] != 2'b00) ||
                  (12'(off_ff) + 12'(m_ff) + 12'd2 > 12'(len_ff));
      pair_bad  = (c1_ff[7:4] != 4'd0) || (c2[7:4] != 4'd0) ||
                  (nidx_ff == 5'(nnd_pkg::NAME_BYTES));
      slen_bad  = (m_ff == 8'd0) ||
                  (sn_ff != '0 && sn_ff >= nnd_pkg::SN_W'(nnd_pkg::SCOPE_BYTES)) ||
                  (12'(off_ff) + 12'(m_ff) + 12'd2 > 12'(len_ff)) ||
                  (9'(sn_dot) + 9'(m_ff) + 9'd1 > 9'(nnd_pkg::SCOPE_BYTES));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nnd_pkg::ST_IDLE: begin
            if (q_valid && q_item.cmd == nnd_pkg::CMD_DECODE) begin
               state_in = start_bad ? nnd_pkg::ST_SUM : nnd_pkg::ST_F_HEAD;
            end
         end
         nnd_pkg::ST_F_HEAD: state_in = nnd_pkg::ST_F_CHK;
         nnd_pkg::ST_F_CHK: begin
            if (rd_byte[7:6] == nnd_pkg::PTR_MARK) begin
               state_in = nnd_pkg::ST_F_PTR;
            end else begin
               state_in = scope_ff ? nnd_pkg::ST_S_LEN : nnd_pkg::ST_N_LEN;
            end
         end
         nnd_pkg::ST_F_PTR:  state_in = ptr_bad ? nnd_pkg::ST_SUM : nnd_pkg::ST_F_HEAD;
         nnd_pkg::ST_N_LEN:  state_in = nlen_bad ? nnd_pkg::ST_SUM : nnd_pkg::ST_N_RD1;
         nnd_pkg::ST_N_RD1:  state_in = nnd_pkg::ST_N_RD2;
         nnd_pkg::ST_N_RD2:  state_in = nnd_pkg::ST_N_PAIR;
         nnd_pkg::ST_N_PAIR: begin
            if (pair_bad) begin
               state_in = nnd_pkg::ST_SUM;
            end else begin
               state_in = (m_ff <= 8'd2) ? nnd_pkg::ST_N_END : nnd_pkg::ST_N_RD1;
            end
         end
         nnd_pkg::ST_N_END: begin
            state_in = (nidx_ff == 5'(nnd_pkg::NAME_BYTES)) ? nnd_pkg::ST_STRIP :
                       nnd_pkg::ST_S_HEAD;
         end
         nnd_pkg::ST_STRIP: begin
            if (!(k_ff != 4'd0 && name_ff[k_ff] == nnd_pkg::CHAR_SPACE)) begin
               state_in = nnd_pkg::ST_S_HEAD;
            end
         end
         nnd_pkg::ST_S_HEAD: state_in = nnd_pkg::ST_S_CHK;
         nnd_pkg::ST_S_CHK:  state_in = (rd_byte == 8'd0) ? nnd_pkg::ST_E_RD : nnd_pkg::ST_F_HEAD;
         nnd_pkg::ST_S_LEN:  state_in = slen_bad ? nnd_pkg::ST_SUM : nnd_pkg::ST_S_RD;
         nnd_pkg::ST_S_RD: begin
            if (m_ff != 8'd0) begin
               state_in = nnd_pkg::ST_S_CPY;
            end else if (labels_ff == nnd_pkg::LBL_W'(nnd_pkg::LABEL_LIMIT)) begin
               state_in = nnd_pkg::ST_SUM;
            end else begin
               state_in = nnd_pkg::ST_S_HEAD;
            end
         end
         nnd_pkg::ST_S_CPY: state_in = nnd_pkg::ST_S_RD;
         nnd_pkg::ST_E_RD:  state_in = (e_ff == sn_ff) ? nnd_pkg::ST_SUM : nnd_pkg::ST_E_OUT;
         nnd_pkg::ST_E_OUT: state_in = out_free ? nnd_pkg::ST_E_RD : nnd_pkg::ST_E_OUT;
         nnd_pkg::ST_SUM:   state_in = out_free ? nnd_pkg::ST_IDLE : nnd_pkg::ST_SUM;
         default:           state_in = nnd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         front_w[63-8*i -: 8] = name_ff[i];
         back_w[63-8*i -: 8]  = name_ff[i+8];
      end
   end

   // Datapath and outputs.
   always_comb begin
      off_in      = off_ff;
      len_in      = len_ff;
      ret_in      = ret_ff;
      gp_in       = gp_ff;
      ok_in       = ok_ff;
      scope_in    = scope_ff;
      m_in        = m_ff;
      c1_in       = c1_ff;
      ntype_in    = ntype_ff;
      hi_in       = hi_ff;
      hops_in     = hops_ff;
      labels_in   = labels_ff;
      nidx_in     = nidx_ff;
      k_in        = k_ff;
      sn_in       = sn_ff;
      e_in        = e_ff;
      name_in     = name_ff;
      scope_we    = 1'b0;
      scope_waddr = sn_ff[nnd_pkg::SCOPE_AW-1:0];
      scope_wdata = rd_byte;
      out_load    = 1'b0;
      rsp_last_in = rsp_last_ff;
      rsp_user_in = rsp_user_ff;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         nnd_pkg::ST_IDLE: begin
            if (q_valid && q_item.cmd == nnd_pkg::CMD_DECODE) begin
               off_in    = OW'(q_item.position);
               len_in    = q_item.packet_length;
               ret_in    = '0;
               gp_in     = 1'b0;
               ok_in     = 1'b0;
               scope_in  = 1'b0;
               hops_in   = '0;
               labels_in = '0;
               nidx_in   = '0;
               sn_in     = '0;
               e_in      = '0;
               ntype_in  = '0;
               for (int i = 0; i < nnd_pkg::NAME_BYTES; i++) begin
                  name_in[i] = 8'd0;
               end
            end
         end
         nnd_pkg::ST_F_CHK: begin
            if (rd_byte[7:6] == nnd_pkg::PTR_MARK) begin
               hi_in = rd_byte[5:0];
               if (!gp_ff) begin
                  ret_in = ret_ff + 12'd2;
               end
               gp_in = 1'b1;
            end else begin
               m_in = rd_byte;
            end
         end
         nnd_pkg::ST_F_PTR: begin
            off_in  = target[OW-1:0];
            hops_in = hops_ff + 1'b1;
         end
         nnd_pkg::ST_N_LEN: begin
            if (!gp_ff) begin
               ret_in = ret_ff + 12'(m_ff) + 12'd2;
            end
            off_in = off_ff + 1'b1;
         end
         nnd_pkg::ST_N_RD2: c1_in = rd_byte - nnd_pkg::CHAR_A;
         nnd_pkg::ST_N_PAIR: begin
            name_in[nidx_ff[3:0]] = {c1_ff[3:0], c2[3:0]};
            nidx_in = nidx_ff + 1'b1;
            off_in  = off_ff + OW'(2);
            m_in    = m_ff - 8'd2;
         end
         nnd_pkg::ST_N_END: begin
            // A full-length name carries its type in the last byte.
            if (nidx_ff == 5'(nnd_pkg::NAME_BYTES)) begin
               ntype_in    = name_ff[15];
               name_in[15] = 8'd0;
               k_in        = 4'd14;
            end
         end
         nnd_pkg::ST_STRIP: begin
            if (k_ff != 4'd0 && name_ff[k_ff] == nnd_pkg::CHAR_SPACE) begin
               name_in[k_ff] = 8'd0;
               k_in = k_ff - 1'b1;
            end
         end
         nnd_pkg::ST_S_CHK: begin
            if (rd_byte == 8'd0) begin
               ok_in = 1'b1;
            end else begin
               hops_in  = '0;
               scope_in = 1'b1;
            end
         end
         nnd_pkg::ST_S_LEN: begin
            if (!gp_ff) begin
               ret_in = ret_ff + 12'(m_ff) + 12'd1;
            end
            scope_we    = sn_ff != '0;
            scope_wdata = nnd_pkg::CHAR_DOT;
            sn_in       = sn_dot;
            off_in      = off_ff + 1'b1;
         end
         nnd_pkg::ST_S_RD: begin
            if (m_ff == 8'd0) begin
               labels_in = labels_ff + 1'b1;
            end
         end
         nnd_pkg::ST_S_CPY: begin
            scope_we = 1'b1;
            sn_in    = sn_ff + 1'b1;
            off_in   = off_ff + 1'b1;
            m_in     = m_ff - 8'd1;
         end
         nnd_pkg::ST_E_OUT: begin
            if (out_free) begin
               out_load    = 1'b1;
               e_in        = e_ff + 1'b1;
               rsp_last_in = 1'b0;
               rsp_user_in = 1'b0;
               rsp_data_in = {{(nnd_pkg::RSP_W-8){1'b0}}, scope_rd_ff};
            end
         end
         nnd_pkg::ST_SUM: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_last_in = 1'b1;
               rsp_user_in = 1'b1;
               rsp_data_in = '0;
               if (ok_ff) begin
                  rsp_data_in[8]       = 1'b1;
                  rsp_data_in[19:9]    = ret_ff[10:0];
                  rsp_data_in[83:20]   = front_w;
                  rsp_data_in[147:84]  = back_w;
                  rsp_data_in[152:148] = nidx_ff;
                  rsp_data_in[160:153] = ntype_ff;
                  rsp_data_in[166:161] = sn_ff[5:0];
               end
            end
         end
         default: begin
            ok_in = ok_ff;
         end
      endcase
      rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nnd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < nnd_pkg::NAME_BYTES; i++) begin
            name_ff[i] <= 8'd0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         name_ff      <= name_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff      <= off_in;
      len_ff      <= len_in;
      ret_ff      <= ret_in;
      gp_ff       <= gp_in;
      ok_ff       <= ok_in;
      scope_ff    <= scope_in;
      m_ff        <= m_in;
      c1_ff       <= c1_in;
      ntype_ff    <= ntype_in;
      hi_ff       <= hi_in;
      hops_ff     <= hops_in;
      labels_ff   <= labels_in;
      nidx_ff     <= nidx_in;
      k_ff        <= k_in;
      sn_ff       <= sn_in;
      e_ff        <= e_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Packet buffer: loads write it, the walker reads one byte a cycle.
   always_ff @(posedge clock) begin
      if (q_pop && q_item.cmd == nnd_pkg::CMD_LOAD) begin
         pkt_mem[q_item.position] <= q_item.byte_value;
      end
      pkt_rd_ff <= pkt_mem[raddr[nnd_pkg::PKT_AW-1:0]];
      oob_ff    <= raddr[OW-1];
   end

   always_ff @(posedge clock) begin
      if (scope_we) begin
         scope_mem[scope_waddr] <= scope_wdata;
      end
      scope_rd_ff <= scope_mem[e_ff[nnd_pkg::SCOPE_AW-1:0]];
   end

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASE_ITEMS    = 22;
   // Random decodes use lengths up to this, so they only reach bytes 0 to RAND_LEN + 1.
   localparam int RAND_LEN       = 62;

   typedef struct {
      bit          is_summary;
      logic [7:0]  scope_char;
      bit          last;
      bit          ok;
      logic [10:0] consumed;
      logic [63:0] name_front;
      logic [63:0] name_back;
      logic [4:0]  name_length;
      logic [7:0]  type_byte;
      logic [5:0]  scope_length;
   } rsp_item_type;

   class name_scoreboard;
      logic [7:0]   pkt [nnd_pkg::PACKET_BYTES];
      logic [7:0]   name_b [nnd_pkg::NAME_BYTES];
      logic [7:0]   scope_b [nnd_pkg::SCOPE_BYTES];
      rsp_item_type awaited_q [$];
      int           errors = 0;
      int           decodes = 0;
      int           good_decodes = 0;
      int           scope_chars = 0;

      function int rd(int a);
         if (a >= 0 && a < nnd_pkg::PACKET_BYTES) return pkt[a];
         return 0;
      endfunction

      // Walks a pointer chain; the first pointer met adds two to the count.
      function bit walk_pointers(inout int off, input int len, inout bit gp, inout int ret);
         int hops;
         hops = 0;
         while ((rd(off) & 'hC0) == 'hC0) begin
            if (!gp) ret += 2;
            gp = 1;
            off = ((rd(off) & 'h3F) << 8) | rd(off + 1);
            if (hops == nnd_pkg::MAX_HOPS || off > len - 2) return 0;
            hops++;
         end
         return 1;
      endfunction

      function int decode_name(int start, int len, output int slen, output int nlen,
                               output int ntype);
         int off, ret, m, n, k, c1, c2, labels;
         bit gp;
         for (int i = 0; i < nnd_pkg::NAME_BYTES; i++) name_b[i] = 8'h00;
         slen = 0; nlen = 0; ntype = 0;
         off = start; ret = 0; n = 0; gp = 0; labels = 0;
         if (len - off < 2) return 0;
         if (!walk_pointers(off, len, gp, ret)) return 0;
         m = rd(off);
         if (m == 0) return 0;
         if ((m & 'hC0) != 0 || off + m + 2 > len) return 0;
         if (!gp) ret += m + 2;
         off++;
         while (m > 0) begin
            c1 = (rd(off) - nnd_pkg::CHAR_A) & 'hFF;
            c2 = (rd(off + 1) - nnd_pkg::CHAR_A) & 'hFF;
            off += 2;
            if ((c1 & 'hF0) != 0 || (c2 & 'hF0) != 0 || n > nnd_pkg::NAME_BYTES - 1)
               return 0;
            name_b[n] = 8'((c1 << 4) | c2);
            n++;
            m -= 2;
         end
         nlen = n;
         if (n == nnd_pkg::NAME_BYTES) begin
            ntype = name_b[15];
            name_b[15] = 8'h00;
            k = 14;
            while (k != 0 && name_b[k] == nnd_pkg::CHAR_SPACE) begin
               name_b[k] = 8'h00;
               k--;
            end
         end
         n = 0;
         while (rd(off) != 0) begin
            if (!walk_pointers(off, len, gp, ret)) return 0;
            m = rd(off);
            if (m == 0) return 0;
            if (!gp) ret += m + 1;
            if (n != 0) begin
               if (n >= nnd_pkg::SCOPE_BYTES) return 0;
               scope_b[n] = nnd_pkg::CHAR_DOT;
               n++;
            end
            if (m + 2 + off > len || n + m + 1 > nnd_pkg::SCOPE_BYTES) return 0;
            off++;
            while (m > 0) begin
               scope_b[n % nnd_pkg::SCOPE_BYTES] = 8'(rd(off));
               n++; off++; m--;
            end
            if (labels == nnd_pkg::LABEL_LIMIT) return 0;
            labels++;
         end
         slen = n;
         return ret;
      endfunction

      function void note_request(logic cmd, logic [9:0] pos, logic [7:0] bv,
                                 logic [10:0] plen);
         int ret, slen, nlen, ntype, len;
         rsp_item_type r;
         if (cmd == nnd_pkg::CMD_LOAD) begin
            pkt[pos] = bv;
            return;
         end
         len = (plen > nnd_pkg::PACKET_BYTES) ? nnd_pkg::PACKET_BYTES : plen;
         ret = decode_name(pos, len, slen, nlen, ntype);
         decodes++;
         if (ret <= 0) begin
            ret = 0; slen = 0; nlen = 0; ntype = 0;
            for (int i = 0; i < nnd_pkg::NAME_BYTES; i++) name_b[i] = 8'h00;
         end else good_decodes++;
         for (int i = 0; i < slen; i++) begin
            r = '{default: 0};
            r.scope_char = scope_b[i];
            awaited_q.push_back(r);
            scope_chars++;
         end
         r = '{default: 0};
         r.is_summary   = 1;
         r.last         = 1;
         r.ok           = (ret > 0);
         r.consumed     = 11'(ret);
         for (int i = 0; i < 8; i++) begin
            r.name_front = {r.name_front[55:0], name_b[i]};
            r.name_back  = {r.name_back[55:0], name_b[i + 8]};
         end
         r.name_length  = 5'(nlen);
         r.type_byte    = 8'(ntype);
         r.scope_length = 6'(slen);
         awaited_q.push_back(r);
      endfunction

      function void check_result(logic user, logic [nnd_pkg::RSP_W-1:0] d, logic lst);
         rsp_item_type e;
         if (awaited_q.size() == 0) begin
            $error("result transfer with nothing awaited: tuser %0b tdata %h", user, d);
            errors++;
            return;
         end
         e = awaited_q.pop_front();
         if (user !== e.is_summary) begin
            $error("is_summary: expected %0h, actual %0h", e.is_summary, user); errors++;
         end
         if (d[7:0] !== e.scope_char) begin
            $error("scope_char: expected %0h, actual %0h", e.scope_char, d[7:0]); errors++;
         end
         if (lst !== e.last) begin
            $error("last: expected %0h, actual %0h", e.last, lst); errors++;
         end
         if (d[8] !== e.ok) begin
            $error("ok: expected %0h, actual %0h", e.ok, d[8]); errors++;
         end
         if (d[19:9] !== e.consumed) begin
            $error("consumed: expected %0d, actual %0d", e.consumed, d[19:9]); errors++;
         end
         if (d[83:20] !== e.name_front) begin
            $error("name_front: expected %h, actual %h", e.name_front, d[83:20]); errors++;
         end
         if (d[147:84] !== e.name_back) begin
            $error("name_back: expected %h, actual %h", e.name_back, d[147:84]); errors++;
         end
         if (d[152:148] !== e.name_length) begin
            $error("name_length: expected %0d, actual %0d", e.name_length, d[152:148]);
            errors++;
         end
         if (d[160:153] !== e.type_byte) begin
            $error("type_byte: expected %0h, actual %0h", e.type_byte, d[160:153]); errors++;
         end
         if (d[166:161] !== e.scope_length) begin
            $error("scope_length: expected %0d, actual %0d", e.scope_length, d[166:161]);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [nnd_pkg::REQ_W-1:0] req_tdata = '0;
   logic                      req_tuser = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [nnd_pkg::RSP_W-1:0] rsp_tdata;
   logic                      rsp_tlast;
   logic                      rsp_tuser;

   name_scoreboard sb = new();
   int send_idle  = 0;
   int recv_stall = 0;
   int hold_left  = 0;
   int hold_requests = 0;
   int hold_seen  = 0;
   int sent_items = 0;
   int quiet_cycles = 0;

   netbios_name_decoder_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   always #2 clock = ~clock;

   // The long hold-off is counted here so that the sender keeps offering meanwhile.
   always @(negedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_left = 600;
         hold_seen = hold_requests;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send(logic cmd, logic [9:0] pos, logic [7:0] bv, logic [10:0] plen);
      req_tuser  <= cmd;
      req_tdata  <= {3'b000, plen, bv, pos};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, pos, bv, plen);
      sent_items++;
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic put(int a, logic [7:0] v);
      send(nnd_pkg::CMD_LOAD, 10'(a), v, 11'($urandom_range(2047)));
   endtask

   task automatic decode(int p, int plen);
      send(nnd_pkg::CMD_DECODE, 10'(p), 8'($urandom_range(255)), 11'(plen));
   endtask

   task automatic put_pointer(int a, int target);
      put(a, 8'hC0 | 8'(target >> 8));
      put(a + 1, 8'(target));
   endtask

   // Writes an encoded name of nb bytes and nlab labels; a full name gets sp trailing spaces before the type.
   task automatic write_name(int base, int nb, bit odd, int sp, int nlab, int minlab,
                             int maxlab, bit term, output int nxt);
      int a, ll;
      logic [7:0] c;
      a = base;
      put(a, 8'(odd ? 2 * nb - 1 : 2 * nb));
      a++;
      for (int i = 0; i < nb; i++) begin
         c = 8'($urandom_range(255));
         if (nb == nnd_pkg::NAME_BYTES && i < 15 && i >= 15 - sp) c = nnd_pkg::CHAR_SPACE;
         put(a, nnd_pkg::CHAR_A + c[7:4]);
         put(a + 1, nnd_pkg::CHAR_A + c[3:0]);
         a += 2;
      end
      for (int l = 0; l < nlab; l++) begin
         ll = $urandom_range(maxlab, minlab);
         put(a, 8'(ll));
         a++;
         for (int j = 0; j < ll; j++) begin
            put(a, 8'($urandom_range(255)));
            a++;
         end
      end
      if (term) begin
         put(a, 8'h00);
         a++;
      end
      nxt = a;
   endtask

   task automatic write_labels(int base, int nlab, int maxlab);
      int a, ll;
      a = base;
      for (int l = 0; l < nlab; l++) begin
         ll = $urandom_range(maxlab, 1);
         put(a, 8'(ll));
         a++;
         for (int j = 0; j < ll; j++) begin
            put(a, 8'($urandom_range(255)));
            a++;
         end
      end
      put(a, 8'h00);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.awaited_q.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   // Random decodes keep their length short, so they never reach an unwritten byte.
   task automatic random_sequence();
      int base, p, nxt, kind, hops, plen, nb, nlab;
      plen = ($urandom_range(9) < 8) ? RAND_LEN : $urandom_range(RAND_LEN);
      kind = $urandom_range(9);
      if (kind == 9) begin
         repeat ($urandom_range(3, 1)) put($urandom_range(RAND_LEN + 1), 8'($urandom_range(255)));
         decode($urandom_range(1023), plen);
         return;
      end
      nb   = ($urandom_range(7) == 0) ? nnd_pkg::NAME_BYTES : $urandom_range(4, 1);
      nlab = $urandom_range(2);
      base = $urandom_range(RAND_LEN - 2 * nb - 4 * nlab - 3);
      write_name(base, nb, $urandom_range(3) == 0, $urandom_range(14),
                 nlab, 1, 3, kind != 4, nxt);
      if (kind == 4) begin
         p = $urandom_range(RAND_LEN - 12);
         put_pointer(nxt, p);
         write_labels(p, $urandom_range(2, 1), 4);
      end
      if (kind == 5) put(base + $urandom_range(nxt - base), 8'($urandom_range(255)));
      p = base;
      if (kind >= 6) begin
         hops = (kind == 8) ? $urandom_range(11, 1) : 1;
         for (int h = 0; h < hops; h++) begin
            nxt = $urandom_range(RAND_LEN - 2);
            put_pointer(nxt, p);
            p = nxt;
         end
      end
      decode(p, plen);
   endtask

   initial begin
      int nxt, stop;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Every byte that a random decode may reach is written first.
      for (int a = 0; a <= RAND_LEN + 1; a++) put(a, 8'($urandom_range(255)));

      // Directed part: the special cases and extreme field values.
      write_name(0, 16, 0, 6, 0, 1, 1, 1, nxt);
      decode(0, nnd_pkg::PACKET_BYTES);
      decode(0, 2047);
      decode(0, 20);
      write_name(40, 4, 0, 0, 2, 2, 2, 1, nxt);
      put_pointer(200, 40);
      decode(200, nnd_pkg::PACKET_BYTES);
      write_name(100, 4, 1, 0, 0, 1, 1, 1, nxt);
      decode(100, nnd_pkg::PACKET_BYTES);
      // A label too long for the scope text.
      put(109, 8'd64);
      decode(100, nnd_pkg::PACKET_BYTES);
      // A label that points back at itself repeats until the label count runs out.
      put(109, 8'd1);
      put(110, 8'($urandom_range(255)));
      put_pointer(111, 109);
      decode(100, nnd_pkg::PACKET_BYTES);
      decode(1023, 2047);
      decode(1023, nnd_pkg::PACKET_BYTES);
      decode(5, 6);
      decode(5, 0);
      put_pointer(300, 1023);
      decode(300, nnd_pkg::PACKET_BYTES);
      for (int h = 0; h < 11; h++) put_pointer(400 + 2 * h, (h == 10) ? 0 : 402 + 2 * h);
      decode(400, nnd_pkg::PACKET_BYTES);
      decode(402, nnd_pkg::PACKET_BYTES);
      put(500, 8'h00);
      decode(500, nnd_pkg::PACKET_BYTES);
      put(500, 8'h41);
      decode(500, nnd_pkg::PACKET_BYTES);
      put(520, 8'h02); put(521, 8'h51); put(522, nnd_pkg::CHAR_A);
      decode(520, nnd_pkg::PACKET_BYTES);
      write_name(800, 2, 0, 0, 0, 1, 1, 0, nxt);
      put_pointer(nxt, 900);
      write_labels(900, 3, 5);
      decode(800, nnd_pkg::PACKET_BYTES);
      put(950, 8'h04); put(951, nnd_pkg::CHAR_A); put(952, nnd_pkg::CHAR_A);
      put(953, 8'h50); put(954, 8'h50); put(955, 8'h00);
      decode(950, nnd_pkg::PACKET_BYTES);
      // Seventeen character pairs overflow the name.
      put(0, 8'd34); put(33, nnd_pkg::CHAR_A); put(34, nnd_pkg::CHAR_A);
      decode(0, nnd_pkg::PACKET_BYTES);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle  = (ph == 1) ? 59 : (ph == 3) ? 15 : 0;
         recv_stall = (ph == 2) ? 59 : (ph == 3) ? 15 : 0;
         stop = sent_items + PHASE_ITEMS;
         while (sent_items < stop) random_sequence();
         if (ph == 0) begin
            // Results back up while decodes keep coming, so the input stalls.
            hold_requests++;
            repeat (6) decode($urandom_range(RAND_LEN - 2), RAND_LEN);
         end
         drain();
      end

      $display("Ran %0d decodes (%0d decoded, %0d scope characters) over %0d transfers,",
               sb.decodes, sb.good_decodes, sb.scope_chars, sent_items);
      $display("covering pointers, chains, scope labels, failures and four idling mixes.");
      if (sb.errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

@@ files.f @@
rtl/nnd_pkg.sv
rtl/nnd_front.sv
rtl/nnd_engine.sv
rtl/netbios_name_decoder_top.sv
sim/tb.sv
